/* design/dwmt_pkg.sv */
// ---------------------------------------------------------------------------
// dwmt_pkg: shared types and constants
// Field widths, parameter defaults and controller/datapath signal groups
// for the delay window minimum tracker.
// ---------------------------------------------------------------------------
package dwmt_pkg;

  localparam int SAMPLE_W = 48;
  localparam int TICK_W   = 32;
  localparam int QUEUE_W  = 49;

  localparam int DEF_HIST_DEPTH   = 10;
  localparam int DEF_RECENT_DEPTH = 1;

  localparam logic [TICK_W-1:0] ROLLOVER_RESET = 32'd60000;

  localparam logic SEL_NOISE = 1'b0;
  localparam logic SEL_BASE  = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [TICK_W-1:0]   tick_t;
  typedef logic signed [QUEUE_W-1:0]  queue_t;

  typedef struct packed {
    logic push;
    logic scan_load;
    logic scan_sel;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_n;
    logic need_b;
    logic scan_done;
  } sts_t;

endpackage

/* design/dwmt_in_if.sv */
// ---------------------------------------------------------------------------
// dwmt_in_if: sample input channel
// Valid/ready channel carrying one delay sample and its timestamp.
// ---------------------------------------------------------------------------
interface dwmt_in_if;
  logic             valid;
  logic             ready;
  dwmt_pkg::sample_t delay_sample;
  dwmt_pkg::tick_t   now_ticks;

  modport source (output valid, output delay_sample, output now_ticks, input ready);
  modport sink   (input valid, input delay_sample, input now_ticks, output ready);
endinterface

/* design/dwmt_out_if.sv */
// ---------------------------------------------------------------------------
// dwmt_out_if: result output channel
// Valid/ready channel carrying current, base and queuing delay.
// ---------------------------------------------------------------------------
interface dwmt_out_if;
  logic              valid;
  logic              ready;
  dwmt_pkg::sample_t recent_min;
  dwmt_pkg::sample_t floor_min;
  dwmt_pkg::queue_t  excess_delay;
  logic              delays_valid;

  modport source (output valid, output recent_min, output floor_min,
                  output excess_delay, output delays_valid, input ready);
  modport sink   (input valid, input recent_min, input floor_min,
                  input excess_delay, input delays_valid, output ready);
endinterface

/* design/dwmt_cfg_if.sv */
// ---------------------------------------------------------------------------
// dwmt_cfg_if: configuration write channel
// Valid/ready channel carrying the rollover_ticks write data.
// ---------------------------------------------------------------------------
interface dwmt_cfg_if;
  logic            valid;
  logic            ready;
  dwmt_pkg::tick_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/dwmt_ram.sv */
// ---------------------------------------------------------------------------
// dwmt_ram: generic single-port-write RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module dwmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/dwmt_ctrl.sv */
// ---------------------------------------------------------------------------
// dwmt_ctrl: sequencing controller
// Accepts a sample, runs the noise and base rescans when needed and
// hands the result to the output register.
// ---------------------------------------------------------------------------
module dwmt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output dwmt_pkg::cmd_t cmd,
  input  dwmt_pkg::sts_t sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD_N = 3'd1;
  localparam logic [2:0] S_SCAN_N = 3'd2;
  localparam logic [2:0] S_LOAD_B = 3'd3;
  localparam logic [2:0] S_SCAN_B = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       need_b_r, need_b_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    need_b_nxt    = need_b_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.scan_sel  = dwmt_pkg::SEL_NOISE;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.push   = 1'b1;
          need_b_nxt = sts.need_b;
          if (sts.need_n) begin
            state_nxt = S_LOAD_N;
          end else if (sts.need_b) begin
            state_nxt = S_LOAD_B;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_LOAD_N: begin
        cmd.scan_load = 1'b1;
        cmd.scan_sel  = dwmt_pkg::SEL_NOISE;
        state_nxt     = S_SCAN_N;
      end
      S_SCAN_N: begin
        if (sts.scan_done) begin
          state_nxt = need_b_r ? S_LOAD_B : S_DONE;
        end
      end
      S_LOAD_B: begin
        cmd.scan_load = 1'b1;
        cmd.scan_sel  = dwmt_pkg::SEL_BASE;
        state_nxt     = S_SCAN_B;
      end
      S_SCAN_B: begin
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      need_b_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      need_b_r    <= need_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* design/dwmt_datapath.sv */
// ---------------------------------------------------------------------------
// dwmt_datapath: window rings, rescan unit and output register
// Noise and base rings in RAM with cached minimum and pointer registers,
// one shared sequential rescan unit, rollover timing and result register.
// ---------------------------------------------------------------------------
module dwmt_datapath #(
  parameter int HIST_DEPTH   = dwmt_pkg::DEF_HIST_DEPTH,
  parameter int RECENT_DEPTH = dwmt_pkg::DEF_RECENT_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dwmt_pkg::cmd_t    cmd,
  output dwmt_pkg::sts_t    sts,
  input  dwmt_pkg::sample_t in_delay_sample,
  input  dwmt_pkg::tick_t   in_now_ticks,
  input  logic              cfg_we,
  input  dwmt_pkg::tick_t   cfg_data,
  output dwmt_pkg::sample_t out_recent_min,
  output dwmt_pkg::sample_t out_floor_min,
  output dwmt_pkg::queue_t  out_excess_delay,
  output logic              out_delays_valid
);

  localparam int NOISE_LEN = RECENT_DEPTH + 1;
  localparam int BASE_LEN  = HIST_DEPTH + 1;
  localparam int NW = $clog2(NOISE_LEN);
  localparam int BW = $clog2(BASE_LEN);
  localparam int SW = (NW > BW) ? NW : BW;

  function automatic logic [NW-1:0] inc_n(input logic [NW-1:0] x);
    return (x == NW'(NOISE_LEN - 1)) ? '0 : x + NW'(1);
  endfunction

  function automatic logic [BW-1:0] inc_b(input logic [BW-1:0] x);
    return (x == BW'(BASE_LEN - 1)) ? '0 : x + BW'(1);
  endfunction

  // ring pointers and cached minimum
  logic [NW-1:0]     n_oldest_r, n_oldest_nxt, n_next_r, n_next_nxt, n_min_pos_r, n_min_pos_nxt;
  dwmt_pkg::sample_t n_min_val_r, n_min_val_nxt;
  logic [BW-1:0]     b_oldest_r, b_oldest_nxt, b_next_r, b_next_nxt, b_min_pos_r, b_min_pos_nxt;
  dwmt_pkg::sample_t b_min_val_r, b_min_val_nxt;
  dwmt_pkg::sample_t b_last_val_r, b_last_val_nxt;
  dwmt_pkg::tick_t   mark_r, mark_nxt;
  dwmt_pkg::tick_t   rollover_ticks_r, rollover_ticks_nxt;

  // rescan unit
  logic          scanning_r, scanning_nxt;
  logic          sel_r, sel_nxt;
  logic [SW-1:0] rd_addr_r, rd_addr_nxt;
  logic [SW-1:0] left_r, left_nxt;
  logic          dv_r, dv_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic          first_r, first_nxt;

  // RAM ports
  logic              n_we, b_we;
  logic [NW-1:0]     n_waddr;
  logic [BW-1:0]     b_waddr;
  dwmt_pkg::sample_t n_rdata, b_rdata;

  // output register
  dwmt_pkg::sample_t out_cur_r, out_base_r;
  dwmt_pkg::queue_t  out_queue_r;
  logic              out_valid_r;

  logic              n_empty, b_empty, roll, scan_done;
  logic [NW-1:0]     n_next_inc;
  logic [BW-1:0]     b_next_inc, b_last;
  dwmt_pkg::tick_t   mark_eff, elapsed;
  dwmt_pkg::sample_t scan_data, scan_min, res_cur, res_base;
  logic              res_valid;

  assign n_empty    = (n_oldest_r == n_next_r);
  assign b_empty    = (b_oldest_r == b_next_r);
  assign n_next_inc = inc_n(n_next_r);
  assign b_next_inc = inc_b(b_next_r);
  assign b_last     = (b_next_r == '0) ? BW'(BASE_LEN - 1) : b_next_r - BW'(1);
  assign mark_eff   = (mark_r == '0) ? in_now_ticks : mark_r;
  assign elapsed    = in_now_ticks - mark_eff;
  assign roll       = (elapsed > rollover_ticks_r);
  assign scan_done  = scanning_r && (left_r == '0) && !dv_r;
  assign scan_data  = (sel_r == dwmt_pkg::SEL_BASE) ? b_rdata : n_rdata;
  assign scan_min   = (sel_r == dwmt_pkg::SEL_BASE) ? b_min_val_r : n_min_val_r;

  always_comb begin
    n_oldest_nxt       = n_oldest_r;
    n_next_nxt         = n_next_r;
    n_min_pos_nxt      = n_min_pos_r;
    n_min_val_nxt      = n_min_val_r;
    b_oldest_nxt       = b_oldest_r;
    b_next_nxt         = b_next_r;
    b_min_pos_nxt      = b_min_pos_r;
    b_min_val_nxt      = b_min_val_r;
    b_last_val_nxt     = b_last_val_r;
    mark_nxt           = mark_r;
    rollover_ticks_nxt = cfg_we ? cfg_data : rollover_ticks_r;
    n_we               = 1'b0;
    n_waddr            = n_next_r;
    b_we               = 1'b0;
    b_waddr            = b_next_r;
    sts                = '0;
    sts.scan_done      = scan_done;
    scanning_nxt       = scanning_r;
    sel_nxt            = sel_r;
    rd_addr_nxt        = rd_addr_r;
    left_nxt           = left_r;
    dv_nxt             = dv_r;
    idx_nxt            = idx_r;
    first_nxt          = first_r;

    if (cmd.push) begin
      // noise ring
      n_we       = 1'b1;
      n_next_nxt = n_next_inc;
      if (n_empty || (in_delay_sample < n_min_val_r)) begin
        n_min_pos_nxt = n_next_r;
        n_min_val_nxt = in_delay_sample;
      end
      if (!n_empty && (n_next_inc == n_oldest_r)) begin
        n_oldest_nxt = inc_n(n_oldest_r);
        sts.need_n   = (n_min_pos_nxt == n_oldest_r);
      end
      // base ring
      if (b_empty || roll) begin
        mark_nxt       = b_empty ? mark_eff : in_now_ticks;
        b_we           = 1'b1;
        b_last_val_nxt = in_delay_sample;
        b_next_nxt     = b_next_inc;
        if (b_empty || (in_delay_sample < b_min_val_r)) begin
          b_min_pos_nxt = b_next_r;
          b_min_val_nxt = in_delay_sample;
        end
        if (!b_empty && (b_next_inc == b_oldest_r)) begin
          b_oldest_nxt = inc_b(b_oldest_r);
          sts.need_b   = (b_min_pos_nxt == b_oldest_r);
        end
      end else begin
        mark_nxt = mark_eff;
        if (in_delay_sample < b_last_val_r) begin
          b_we           = 1'b1;
          b_waddr        = b_last;
          b_last_val_nxt = in_delay_sample;
          if (in_delay_sample < b_min_val_r) begin
            b_min_pos_nxt = b_last;
            b_min_val_nxt = in_delay_sample;
          end
        end
      end
    end

    if (cmd.scan_load) begin
      scanning_nxt = 1'b1;
      sel_nxt      = cmd.scan_sel;
      dv_nxt       = 1'b0;
      first_nxt    = 1'b1;
      if (cmd.scan_sel == dwmt_pkg::SEL_BASE) begin
        rd_addr_nxt = SW'(b_oldest_r);
        left_nxt    = SW'(BASE_LEN - 1);
      end else begin
        rd_addr_nxt = SW'(n_oldest_r);
        left_nxt    = SW'(NOISE_LEN - 1);
      end
    end else if (scanning_r) begin
      dv_nxt  = (left_r != '0);
      idx_nxt = rd_addr_r;
      if (left_r != '0) begin
        left_nxt = left_r - SW'(1);
        if (sel_r == dwmt_pkg::SEL_BASE) begin
          rd_addr_nxt = (rd_addr_r == SW'(BASE_LEN - 1)) ? '0 : rd_addr_r + SW'(1);
        end else begin
          rd_addr_nxt = (rd_addr_r == SW'(NOISE_LEN - 1)) ? '0 : rd_addr_r + SW'(1);
        end
      end
      if (dv_r) begin
        first_nxt = 1'b0;
        if (first_r || (scan_data < scan_min)) begin
          if (sel_r == dwmt_pkg::SEL_BASE) begin
            b_min_pos_nxt = idx_r[BW-1:0];
            b_min_val_nxt = scan_data;
          end else begin
            n_min_pos_nxt = idx_r[NW-1:0];
            n_min_val_nxt = scan_data;
          end
        end
      end
      if (scan_done) begin
        scanning_nxt = 1'b0;
      end
    end
  end

  assign res_valid = !n_empty && !b_empty;
  assign res_cur   = n_empty ? '0 : n_min_val_r;
  assign res_base  = b_empty ? '0 : b_min_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_oldest_r       <= '0;
      n_next_r         <= '0;
      n_min_pos_r      <= '0;
      b_oldest_r       <= '0;
      b_next_r         <= '0;
      b_min_pos_r      <= '0;
      mark_r           <= '0;
      rollover_ticks_r <= dwmt_pkg::ROLLOVER_RESET;
      scanning_r       <= 1'b0;
      left_r           <= '0;
      dv_r             <= 1'b0;
    end else begin
      n_oldest_r       <= n_oldest_nxt;
      n_next_r         <= n_next_nxt;
      n_min_pos_r      <= n_min_pos_nxt;
      b_oldest_r       <= b_oldest_nxt;
      b_next_r         <= b_next_nxt;
      b_min_pos_r      <= b_min_pos_nxt;
      mark_r           <= mark_nxt;
      rollover_ticks_r <= rollover_ticks_nxt;
      scanning_r       <= scanning_nxt;
      left_r           <= left_nxt;
      dv_r             <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_min_val_r  <= n_min_val_nxt;
    b_min_val_r  <= b_min_val_nxt;
    b_last_val_r <= b_last_val_nxt;
    sel_r        <= sel_nxt;
    rd_addr_r    <= rd_addr_nxt;
    idx_r        <= idx_nxt;
    first_r      <= first_nxt;
    if (cmd.out_load) begin
      out_cur_r   <= res_cur;
      out_base_r  <= res_base;
      out_valid_r <= res_valid;
      out_queue_r <= res_valid ? (dwmt_pkg::queue_t'(res_cur) - dwmt_pkg::queue_t'(res_base))
                               : '0;
    end
  end

  dwmt_ram #(
    .WIDTH (dwmt_pkg::SAMPLE_W),
    .DEPTH (NOISE_LEN)
  ) u_noise_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (in_delay_sample),
    .raddr (rd_addr_r[NW-1:0]),
    .rdata (n_rdata)
  );

  dwmt_ram #(
    .WIDTH (dwmt_pkg::SAMPLE_W),
    .DEPTH (BASE_LEN)
  ) u_base_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (in_delay_sample),
    .raddr (rd_addr_r[BW-1:0]),
    .rdata (b_rdata)
  );

  assign out_recent_min   = out_cur_r;
  assign out_floor_min    = out_base_r;
  assign out_excess_delay = out_queue_r;
  assign out_delays_valid = out_valid_r;

endmodule

/* design/delay_window_min_tracker.sv */
// ---------------------------------------------------------------------------
// delay_window_min_tracker: current and base delay filter
// Usage:
//   in_chan  - one delay sample plus tick timestamp per transfer.
//   out_chan - one result per sample: current delay (noise window minimum),
//              base delay (base history minimum), queuing delay, valid flag.
//   cfg_chan - writes rollover_ticks; always ready, write only while idle.
// Timing: a sample is taken only while the controller is idle. The push
//   is done in the same cycle the sample is taken, and the result is
//   loaded into the output register from the done state. Evicting the
//   minimum of a ring adds a sequential RAM rescan of that ring (noise or
//   base), one entry read per cycle from the ring RAM, before the result
//   is loaded; a new sample is not taken until the result is loaded.
// Reset: rst_n clears both rings to empty, the rollover mark to unset and
//   rollover_ticks to 60000; no clearing pass is needed.
// Stall: a held result stays in the output register; the next sample is
//   taken and processed, then waits until the output register frees.
// ---------------------------------------------------------------------------
module delay_window_min_tracker #(
  parameter int HIST_DEPTH   = dwmt_pkg::DEF_HIST_DEPTH,
  parameter int RECENT_DEPTH = dwmt_pkg::DEF_RECENT_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  dwmt_in_if.sink     in_chan,
  dwmt_out_if.source  out_chan,
  dwmt_cfg_if.sink    cfg_chan
);

  dwmt_pkg::cmd_t cmd;
  dwmt_pkg::sts_t sts;

  assign cfg_chan.ready = 1'b1;

  dwmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dwmt_datapath #(
    .HIST_DEPTH   (HIST_DEPTH),
    .RECENT_DEPTH (RECENT_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_delay_sample  (in_chan.delay_sample),
    .in_now_ticks     (in_chan.now_ticks),
    .cfg_we           (cfg_chan.valid),
    .cfg_data         (cfg_chan.data),
    .out_recent_min   (out_chan.recent_min),
    .out_floor_min    (out_chan.floor_min),
    .out_excess_delay (out_chan.excess_delay),
    .out_delays_valid (out_chan.delays_valid)
  );

endmodule

/* tb/delay_window_min_tracker_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// delay_window_min_tracker_test: self-checking bench for the delay filter
// Sends delay samples with tick stamps through bursty valid/ready traffic
// while the result side stalls on its own pattern. Each transfer is run
// through an in-bench model of the noise window and the base history, and
// every result is checked field by field against it. The rollover period is
// rewritten between phases, including 1 and the largest 32-bit value.
// ---------------------------------------------------------------------------
module delay_window_min_tracker_test;

  localparam int NOISE_LEN  = dwmt_pkg::DEF_RECENT_DEPTH + 1;
  localparam int BASE_LEN   = dwmt_pkg::DEF_HIST_DEPTH + 1;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASE_SIZE = 150;
  localparam logic NOISE_WIN = dwmt_pkg::SEL_NOISE;
  localparam logic BASE_WIN  = dwmt_pkg::SEL_BASE;
  localparam dwmt_pkg::sample_t SAMPLE_MAX = {1'b0, {(dwmt_pkg::SAMPLE_W-1){1'b1}}};
  localparam dwmt_pkg::sample_t SAMPLE_MIN = {1'b1, {(dwmt_pkg::SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    dwmt_pkg::sample_t delay;
    dwmt_pkg::tick_t   now;
  } sample_item_t;

  typedef struct packed {
    dwmt_pkg::sample_t cur;
    dwmt_pkg::sample_t base;
    dwmt_pkg::queue_t  queue;
    logic              valid;
  } delay_result_t;

  typedef struct {
    dwmt_pkg::sample_t slot [BASE_LEN];
    int unsigned       len;
    int unsigned       oldest;
    int unsigned       nxt;
    int unsigned       min_pos;
  } delay_ring_t;

  logic clk = 1'b0;
  logic rst_n;

  dwmt_in_if  in_if ();
  dwmt_out_if out_if ();
  dwmt_cfg_if cfg_if ();

  delay_window_min_tracker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #1 clk = ~clk;

  delay_ring_t     rings [2];
  dwmt_pkg::tick_t roll_ticks;
  dwmt_pkg::tick_t roll_mark;
  sample_item_t    sample_backlog [$];
  delay_result_t   pending_delays [$];
  logic            in_accepted = 1'b0;
  int              fail_count = 0;
  int              idle_cycles = 0;
  int              burst_left = 0;
  int              gap_left = 0;
  int              ready_mode = 0;
  int              ready_left = 0;

  task automatic report_mismatch(input string field, input longint got, input longint want);
    fail_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
  endtask

  function automatic logic ring_empty(input logic win);
    return rings[win].oldest == rings[win].nxt;
  endfunction

  function automatic void ring_push(input logic win, input dwmt_pkg::sample_t v);
    int unsigned i;
    if (ring_empty(win)) begin
      rings[win].slot[rings[win].nxt] = v;
      rings[win].min_pos = rings[win].nxt;
      rings[win].nxt = (rings[win].nxt + 1) % rings[win].len;
      return;
    end
    rings[win].slot[rings[win].nxt] = v;
    if (v < rings[win].slot[rings[win].min_pos]) rings[win].min_pos = rings[win].nxt;
    rings[win].nxt = (rings[win].nxt + 1) % rings[win].len;
    if (rings[win].nxt == rings[win].oldest) begin
      // evicting the minimum: rescan what remains
      if (rings[win].min_pos == rings[win].oldest) begin
        i = (rings[win].oldest + 1) % rings[win].len;
        rings[win].min_pos = i;
        while (i != rings[win].nxt) begin
          if (rings[win].slot[i] < rings[win].slot[rings[win].min_pos]) rings[win].min_pos = i;
          i = (i + 1) % rings[win].len;
        end
      end
      rings[win].oldest = (rings[win].oldest + 1) % rings[win].len;
    end
  endfunction

  function automatic delay_result_t predict_delays(input dwmt_pkg::sample_t v,
                                                   input dwmt_pkg::tick_t now);
    delay_result_t   r;
    dwmt_pkg::tick_t elapsed;
    int unsigned     last;
    r = '0;
    ring_push(NOISE_WIN, v);
    if (roll_mark == '0) roll_mark = now;
    elapsed = now - roll_mark;
    if (ring_empty(BASE_WIN)) begin
      ring_push(BASE_WIN, v);
    end else if (elapsed > roll_ticks) begin
      roll_mark = now;
      ring_push(BASE_WIN, v);
    end else begin
      last = (rings[BASE_WIN].nxt + rings[BASE_WIN].len - 1) % rings[BASE_WIN].len;
      if (v < rings[BASE_WIN].slot[last]) begin
        rings[BASE_WIN].slot[last] = v;
        if (v < rings[BASE_WIN].slot[rings[BASE_WIN].min_pos]) rings[BASE_WIN].min_pos = last;
      end
    end
    r.valid = !ring_empty(NOISE_WIN) && !ring_empty(BASE_WIN);
    if (!ring_empty(NOISE_WIN)) r.cur = rings[NOISE_WIN].slot[rings[NOISE_WIN].min_pos];
    if (!ring_empty(BASE_WIN)) r.base = rings[BASE_WIN].slot[rings[BASE_WIN].min_pos];
    if (r.valid) r.queue = dwmt_pkg::queue_t'(r.cur) - dwmt_pkg::queue_t'(r.base);
    return r;
  endfunction

  task automatic queue_sample(input dwmt_pkg::sample_t d, input dwmt_pkg::tick_t t);
    sample_item_t s;
    s.delay = d;
    s.now = t;
    sample_backlog.push_back(s);
  endtask

  task automatic wait_drained();
    while (sample_backlog.size() != 0 || pending_delays.size() != 0) @(posedge clk);
  endtask

  task automatic write_rollover(input dwmt_pkg::tick_t v);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(posedge clk); while (!cfg_if.ready);
    roll_ticks = v;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // sender: bursts of transfers separated by random gaps
  always @(negedge clk) begin
    logic hold;
    hold = in_if.valid && !in_accepted;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.delay_sample <= '0;
      in_if.now_ticks <= '0;
    end else if (!hold) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (sample_backlog.size() != 0) begin
        in_if.valid <= 1'b1;
        in_if.delay_sample <= sample_backlog[0].delay;
        in_if.now_ticks <= sample_backlog[0].now;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
        end else begin
          burst_left--;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    // receiver: stall pattern switches mode at random intervals
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(16, 96);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      2: out_if.ready <= ($urandom_range(0, 3) == 0);
      default: out_if.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    delay_result_t want;
    logic          out_fire;
    logic          cfg_fire;
    if (rst_n) begin
      in_accepted = in_if.valid && in_if.ready;
      out_fire = out_if.valid && out_if.ready;
      cfg_fire = cfg_if.valid && cfg_if.ready;
      if (in_accepted) begin
        pending_delays.push_back(predict_delays(in_if.delay_sample, in_if.now_ticks));
        void'(sample_backlog.pop_front());
      end
      if (out_fire) begin
        if (pending_delays.size() == 0) begin
          report_mismatch("unexpected result, recent_min", out_if.recent_min, 0);
        end else begin
          want = pending_delays.pop_front();
          if (out_if.recent_min !== want.cur)
            report_mismatch("recent_min", out_if.recent_min, want.cur);
          if (out_if.floor_min !== want.base)
            report_mismatch("floor_min", out_if.floor_min, want.base);
          if (out_if.excess_delay !== want.queue)
            report_mismatch("excess_delay", out_if.excess_delay, want.queue);
          if (out_if.delays_valid !== want.valid)
            report_mismatch("delays_valid", out_if.delays_valid, want.valid);
        end
      end
      if (in_accepted || out_fire || cfg_fire) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    dwmt_pkg::tick_t   roll_plan [5];
    dwmt_pkg::tick_t   t;
    dwmt_pkg::tick_t   step;
    longint            level;
    dwmt_pkg::sample_t d;
    int                sel;

    rst_n = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    for (int w = 0; w < 2; w++) begin
      for (int k = 0; k < BASE_LEN; k++) rings[w].slot[k] = '0;
      rings[w].oldest = 0;
      rings[w].nxt = 0;
      rings[w].min_pos = 0;
    end
    rings[NOISE_WIN].len = NOISE_LEN;
    rings[BASE_WIN].len = BASE_LEN;
    roll_mark = '0;
    roll_ticks = dwmt_pkg::ROLLOVER_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset period, unset mark, field extremes, boundary, wrap
    queue_sample('0, '0);
    queue_sample(SAMPLE_MAX, '0);
    queue_sample(SAMPLE_MIN, 32'd100);
    queue_sample(SAMPLE_MAX, 32'd60100);
    queue_sample(-48'sd1, 32'd60101);
    queue_sample(SAMPLE_MAX, 32'd60101);
    t = 32'd60101;
    for (int k = 0; k < 12; k++) begin
      t = t + 32'd60001;
      queue_sample(dwmt_pkg::sample_t'((k % 3) * 40 - k * 7), t);
    end
    queue_sample(dwmt_pkg::sample_t'(123), 32'hFFFF_FFFF);
    queue_sample(dwmt_pkg::sample_t'(5), 32'h0000_0010);
    queue_sample(dwmt_pkg::sample_t'(-7), 32'h0001_0000);
    wait_drained();

    roll_plan[0] = 32'd1;
    roll_plan[1] = 32'hFFFF_FFFF;
    roll_plan[2] = dwmt_pkg::tick_t'($urandom_range(50, 5000));
    roll_plan[3] = 32'h8000_0000;
    roll_plan[4] = dwmt_pkg::ROLLOVER_RESET;
    level = 0;
    t = $urandom;
    foreach (roll_plan[p]) begin
      write_rollover(roll_plan[p]);
      for (int n = 0; n < PHASE_SIZE; n++) begin
        sel = $urandom_range(0, 15);
        if (sel < 5) step = roll_plan[p] + dwmt_pkg::tick_t'($urandom_range(1, 4));
        else if (sel < 7) step = roll_plan[p];
        else if (sel < 13) step = dwmt_pkg::tick_t'($urandom_range(0, roll_plan[p] / 2));
        else if (sel < 15) step = '0;
        else step = $urandom;
        t = t + step;
        if ($urandom_range(0, 31) == 0) level = longint'($urandom_range(0, 2000000)) - 1000000;
        sel = $urandom_range(0, 49);
        if (sel == 0) d = SAMPLE_MAX;
        else if (sel == 1) d = SAMPLE_MIN;
        else if (sel < 7) d = dwmt_pkg::sample_t'({$urandom, $urandom});
        else d = dwmt_pkg::sample_t'(level + longint'($urandom_range(0, 400)) - 200);
        queue_sample(d, t);
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (pending_delays.size() != 0)
      report_mismatch("missing results", pending_delays.size(), 0);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* delay_window_min_tracker.f */
design/dwmt_pkg.sv
design/dwmt_in_if.sv
design/dwmt_out_if.sv
design/dwmt_cfg_if.sv
design/dwmt_ram.sv
design/dwmt_ctrl.sv
design/dwmt_datapath.sv
design/delay_window_min_tracker.sv
tb/delay_window_min_tracker_test.sv
